// ===== rtl/cms_pkg.sv =====
// Shared types and constants of the CAN message segmenter.
// Holds the input item, the frame result and the packet id request structs.
// No dependencies.
package cms_pkg;

  localparam int FRAME_BYTES      = 8;
  localparam int SINGLE_FRAME_MAX = 8;
  localparam int LEN_W            = 11;
  localparam int LEN_CW           = LEN_W + 1;
  localparam int SEQ_W            = 7;
  localparam int CNT_W            = 4;
  localparam int PAYLOAD_W        = 64;
  localparam int LANES            = PAYLOAD_W / 8;

  typedef struct packed {
    logic [7:0]       prio;
    logic [7:0]       source;
    logic [7:0]       dest;
    logic [LEN_W-1:0] len;
    logic [7:0]       data;
  } item_t;

  typedef struct packed {
    logic [7:0]           prio;
    logic [7:0]           source;
    logic [7:0]           dest;
    logic [7:0]           packet;
    logic [SEQ_W-1:0]     seq;
    logic [SEQ_W-1:0]     seq_final;
    logic [CNT_W-1:0]     count;
    logic [PAYLOAD_W-1:0] payload;
    logic                 eom;
  } frame_t;

  typedef struct packed {
    logic       take;
    logic [3:0] nibble;
  } id_req_t;

endpackage

// ===== rtl/cms_id_table.sv =====
// Per-source packet id counters of the CAN message segmenter.
// Depends on cms_pkg for the id request struct.
module cms_id_table import cms_pkg::*; #(
  parameter int MODULE_SLOTS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  id_req_t    req_i,
  output logic [7:0] id_o
);

  localparam int SLOT_W = (MODULE_SLOTS > 1) ? $clog2(MODULE_SLOTS) : 1;

  // Maps a source nibble onto a counter slot; built at elaboration.
  function automatic logic [15:0][SLOT_W-1:0] build_map();
    logic [15:0][SLOT_W-1:0] map;
    for (int i = 0; i < 16; i++) begin
      map[i] = SLOT_W'(i % MODULE_SLOTS);
    end
    return map;
  endfunction

  localparam logic [15:0][SLOT_W-1:0] SlotMap = build_map();

  logic [SLOT_W-1:0] slot;
  logic [7:0]        tbl_q [MODULE_SLOTS];

  assign slot = SlotMap[req_i.nibble];
  assign id_o = tbl_q[slot];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MODULE_SLOTS; i++) begin
        tbl_q[i] <= 8'd0;
      end
    end else if (req_i.take) begin
      tbl_q[slot] <= id_o + 8'd1;
    end
  end

  a_take_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.take |=> tbl_q[$past(slot)] == 8'($past(id_o) + 8'd1))
    else $error("packet id counter did not advance after a take");

endmodule

// ===== rtl/cms_framer.sv =====
// Frame packing state and result logic of the CAN message segmenter.
// Depends on cms_pkg; reads the packet id from cms_id_table.
module cms_framer import cms_pkg::*; #(
  parameter int MAX_MESSAGE_BYTES = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  item_t      item_i,
  input  logic       step_i,
  input  logic [7:0] table_id_i,
  output id_req_t    id_req_o,
  output logic       emit_o,
  output frame_t     frame_o
);

  localparam int POS_W = $clog2(MAX_MESSAGE_BYTES);
  localparam logic [LEN_CW-1:0] MaxLen = LEN_CW'(MAX_MESSAGE_BYTES);

  logic [POS_W-1:0]     pos_q;
  logic [PAYLOAD_W-1:0] buf_q;
  logic [CNT_W-1:0]     fill_q;
  logic [SEQ_W-1:0]     frame_q;
  logic [7:0]           pkt_q;

  logic [LEN_CW-1:0]    len_c;
  logic [LEN_CW-1:0]    pos_inc;
  logic [LEN_CW-1:0]    total_m1;
  logic                 single;
  logic                 first;
  logic                 last;
  logic                 emit;
  logic [CNT_W-1:0]     limit;
  logic [CNT_W-1:0]     fill_nx;
  logic [7:0]           pkt;
  logic [PAYLOAD_W-1:0] buf_nx;

  // A zero length counts as one byte, and an overlong one is clipped.
  always_comb begin
    if (item_i.len == '0) begin
      len_c = LEN_CW'(1);
    end else if ({1'b0, item_i.len} > MaxLen) begin
      len_c = MaxLen;
    end else begin
      len_c = {1'b0, item_i.len};
    end
  end

  assign single = len_c <= LEN_CW'(SINGLE_FRAME_MAX);
  assign limit  = single ? CNT_W'(SINGLE_FRAME_MAX) : CNT_W'(FRAME_BYTES);
  assign first  = pos_q == '0;
  assign pkt    = first ? (single ? 8'd0 : table_id_i) : pkt_q;

  assign id_req_o.take   = step_i && first && !single;
  assign id_req_o.nibble = item_i.source[3:0];

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      buf_nx[8*k +: 8] = (fill_q == CNT_W'(k)) ? item_i.data : buf_q[8*k +: 8];
    end
  end

  assign fill_nx  = fill_q + CNT_W'(1);
  assign pos_inc  = LEN_CW'(pos_q) + LEN_CW'(1);
  assign last     = pos_inc >= len_c;
  assign emit     = last || (fill_nx >= limit);
  assign total_m1 = LEN_CW'((len_c + LEN_CW'(FRAME_BYTES - 1)) / FRAME_BYTES) - LEN_CW'(1);

  assign emit_o            = emit;
  assign frame_o.prio      = item_i.prio;
  assign frame_o.source    = item_i.source;
  assign frame_o.dest      = item_i.dest;
  assign frame_o.packet    = single ? 8'd0 : pkt;
  assign frame_o.seq       = single ? '0 : frame_q;
  assign frame_o.seq_final = single ? '0 : total_m1[SEQ_W-1:0];
  assign frame_o.count     = fill_nx;
  assign frame_o.payload   = buf_nx;
  assign frame_o.eom       = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      buf_q   <= '0;
      fill_q  <= '0;
      frame_q <= '0;
      pkt_q   <= 8'd0;
    end else if (step_i) begin
      pkt_q <= pkt;
      if (emit) begin
        buf_q  <= '0;
        fill_q <= '0;
        if (last) begin
          frame_q <= '0;
          pos_q   <= '0;
        end else begin
          frame_q <= frame_q + SEQ_W'(1);
          pos_q   <= POS_W'(pos_inc);
        end
      end else begin
        buf_q  <= buf_nx;
        fill_q <= fill_nx;
        pos_q  <= POS_W'(pos_inc);
      end
    end
  end

  a_emit_clears_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && emit |=> fill_q == '0)
    else $error("frame fill not cleared after a frame went out");

  a_gather_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !emit |=> fill_q == CNT_W'($past(fill_q) + CNT_W'(1)))
    else $error("frame fill did not count a gathered byte");

  a_start_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q == '0 |-> frame_q == '0 && fill_q == '0)
    else $error("message start with a nonzero frame index or fill");

endmodule

// ===== rtl/can_message_segmenter_core.sv =====
// Top level of the CAN message segmenter: input register, framer, packet id
// table and output register. Depends on cms_pkg, cms_framer, cms_id_table.
//
// Usage: a message enters one byte per item on the input channel, every byte
// carrying the full header (priority, source, destination, total length).
// The block packs bytes low byte first into CAN frames and puts out one frame
// item when eight bytes are gathered or the message's last byte arrives.
// Messages of up to eight bytes give one frame with packet number and
// sequence fields zero; longer ones take a packet id from a per-source
// counter and are split into numbered frames.
// Both channels use valid and stall. One item can be accepted every cycle
// while the input is not stalled. An item is registered in the input register
// at its accept edge and then processed by the framer logic, which feeds the
// frame it closes into the output register; the frame stays there until the
// receiver stops stalling. A stalled output blocks the input only when the
// waiting byte would close a further frame; bytes that close no frame still
// flow. Reset clears the packing state, the output valid and all packet id
// counters at once; the block is ready in the first cycle after reset.
module can_message_segmenter_core import cms_pkg::*; #(
  parameter int MAX_MESSAGE_BYTES = 1024,
  parameter int MODULE_SLOTS      = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           priority_req_i,
  input  logic [7:0]           source_id_i,
  input  logic [7:0]           dest_id_i,
  input  logic [LEN_W-1:0]     msg_length_i,
  input  logic [7:0]           data_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           frame_priority_o,
  output logic [7:0]           frame_source_o,
  output logic [7:0]           frame_dest_o,
  output logic [7:0]           packet_number_o,
  output logic [SEQ_W-1:0]     seq_index_o,
  output logic [SEQ_W-1:0]     seq_final_index_o,
  output logic [CNT_W-1:0]     byte_count_o,
  output logic [PAYLOAD_W-1:0] payload_o,
  output logic                 end_of_message_o
);

  logic    s1_valid_q;
  item_t   s1_item_q;
  logic    out_valid_q;
  frame_t  out_frame_q;

  logic    out_free;
  logic    s1_adv;
  logic    emit;
  logic    in_acc;
  frame_t  frame;
  id_req_t id_req;
  logic [7:0] table_id;

  cms_framer #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_framer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (s1_item_q),
    .step_i    (s1_adv),
    .table_id_i(table_id),
    .id_req_o  (id_req),
    .emit_o    (emit),
    .frame_o   (frame)
  );

  cms_id_table #(
    .MODULE_SLOTS(MODULE_SLOTS)
  ) u_id_table (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (id_req),
    .id_o  (table_id)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!emit || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_adv && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q.prio   <= priority_req_i;
      s1_item_q.source <= source_id_i;
      s1_item_q.dest   <= dest_id_i;
      s1_item_q.len    <= msg_length_i;
      s1_item_q.data   <= data_byte_i;
    end
    if (s1_adv && emit) begin
      out_frame_q <= frame;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign frame_priority_o  = out_frame_q.prio;
  assign frame_source_o    = out_frame_q.source;
  assign frame_dest_o      = out_frame_q.dest;
  assign packet_number_o   = out_frame_q.packet;
  assign seq_index_o       = out_frame_q.seq;
  assign seq_final_index_o = out_frame_q.seq_final;
  assign byte_count_o      = out_frame_q.count;
  assign payload_o         = out_frame_q.payload;
  assign end_of_message_o  = out_frame_q.eom;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && emit && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked frame");

  a_frame_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && emit |=> out_valid_q)
    else $error("processed frame did not reach the output register");

endmodule
